// File: sv/lfgr_pkg.sv
// shared types, constants and register codes for the linear fade gain ramp
`timescale 1ns / 1ps

package lfgr_pkg;

    // defaults for the top level parameters
    localparam int DEF_MAX_SAMPLES = 65536;
    localparam int DEF_SAMPLE_BITS = 16;

    // gain and window field widths
    localparam int GAIN_W     = 16;
    localparam int BOUND_W    = 16;
    localparam int GAIN_MAX   = 32768;
    localparam int FRAC_EXTRA = 16;

    // accumulator in Q2.30, step signed Q2.30
    localparam int ACC_W = GAIN_W + FRAC_EXTRA;
    localparam int INC_W = ACC_W + 1;

    // gain step divider: one quotient bit per cycle
    localparam int DVSR_W    = BOUND_W + 1;
    localparam int DIV_STEPS = ACC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT   = 3'd4;

    // reset value of the upper gain, unity
    localparam logic [GAIN_W-1:0] HIGH_GAIN_RST = 16'd16384;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // item accepted
        logic first;   // accepted item opens a buffer
        logic step;    // one divider iteration
        logic finish;  // last divider iteration, commit the step
    } lfgr_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_last;
    } lfgr_stat_t;

endpackage

// File: sv/lfgr_if.sv
// stream interfaces for sample items in and out
`timescale 1ns / 1ps

interface lfgr_in_if import lfgr_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          buffer_first;

    modport source (output valid, output sample_in, output buffer_first, input ready);
    modport sink   (input valid, input sample_in, input buffer_first, output ready);
endinterface

interface lfgr_out_if import lfgr_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          in_fade;

    modport source (output valid, output sample_out, output in_fade, input ready);
    modport sink   (input valid, input sample_out, input in_fade, output ready);
endinterface

// File: sv/lfgr_ctrl.sv
// controller: handshakes, output slot and divider sequencing
`timescale 1ns / 1ps

module lfgr_ctrl import lfgr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_first,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output lfgr_cmd_t  cmd,
    input  lfgr_stat_t stat
);

    localparam logic ST_RUN = 1'b0;
    localparam logic ST_DIV = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    // take an item when running and the output slot frees up
    assign in_ready = (state_reg == ST_RUN) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // commands
    assign cmd.load   = accept;
    assign cmd.first  = accept && in_first;
    assign cmd.step   = (state_reg == ST_DIV);
    assign cmd.finish = (state_reg == ST_DIV) && stat.div_last;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (accept && in_first)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    // output slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/lfgr_dp.sv
// datapath: config registers, index, gain ramp, step divider, multiply and saturate
`timescale 1ns / 1ps

module lfgr_dp import lfgr_pkg::*; #(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  lfgr_cmd_t                     cmd,
    output lfgr_stat_t                    stat,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          in_fade
);

    localparam int IW = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = (IW > BOUND_W) ? IW : BOUND_W;
    localparam int PW = SAMPLE_BITS + GAIN_W + 2;
    localparam int RW = PW - (GAIN_W - 2);

    // configuration registers
    logic [GAIN_W-1:0]  low_gain_reg, high_gain_reg;
    logic [BOUND_W-1:0] fade_start_reg, fade_end_reg;
    logic               fade_out_reg;

    // stream state
    logic [IW-1:0]           idx_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic signed [INC_W-1:0] inc_reg;

    // divider state
    logic [ACC_W-1:0]     dq_reg;
    logic [DVSR_W-1:0]    rem_reg;
    logic [DVSR_W-1:0]    dvsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 neg_reg, empty_reg, pend_reg;

    // result register
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic                          in_fade_reg;

    logic [GAIN_W-1:0]       lo_c, hi_c, gain_start, gain_cur;
    logic                    win_ok, in_win;
    logic [IW-1:0]           cur_idx;
    logic [CW-1:0]           idx_ext;
    logic [ACC_W-1:0]        start_acc;
    logic signed [PW-1:0]    s_ext, g_ext, prod, rnd;
    logic signed [RW-1:0]    scaled, smax, smin;
    logic signed [SAMPLE_BITS-1:0] sat, res;
    logic signed [GAIN_W:0]  diff;
    logic [GAIN_W-1:0]       diff_mag;
    logic [DVSR_W:0]         rem_sh;
    logic                    ge;
    logic [DVSR_W-1:0]       rem_step;
    logic [ACC_W-1:0]        dq_step;
    logic signed [INC_W-1:0] q_ext, inc_new, inc_src;
    logic signed [INC_W:0]   acc_sum;
    logic [ACC_W-1:0]        acc_clamped;

    // gain clamp to 0..2
    assign lo_c = (low_gain_reg > GAIN_W'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX) : low_gain_reg;
    assign hi_c = (high_gain_reg > GAIN_W'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX) : high_gain_reg;
    assign gain_start = fade_out_reg ? hi_c : lo_c;
    assign start_acc  = {gain_start, {FRAC_EXTRA{1'b0}}};

    // window test on the current index
    assign win_ok  = fade_end_reg >= fade_start_reg;
    assign cur_idx = cmd.first ? '0 : idx_reg;
    assign idx_ext = CW'(cur_idx);
    assign in_win  = win_ok && (idx_ext >= CW'(fade_start_reg))
                            && (idx_ext <= CW'(fade_end_reg));

    // sample times gain, round half up, saturate
    assign gain_cur = cmd.first ? gain_start : acc_reg[ACC_W-1 -: GAIN_W];
    assign s_ext  = PW'(sample_in);
    assign g_ext  = $signed(PW'(gain_cur));
    assign prod   = s_ext * g_ext;
    assign rnd    = prod + $signed(PW'(1 << (GAIN_W - 3)));
    assign scaled = rnd[PW-1 -: RW];
    assign smax   = $signed({{(RW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
    assign smin   = $signed({{(RW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}});

    always_comb
    begin
        if (scaled > smax)
        begin
            sat = smax[SAMPLE_BITS-1:0];
        end
        else if (scaled < smin)
        begin
            sat = smin[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat = scaled[SAMPLE_BITS-1:0];
        end
    end

    assign res = in_win ? sat : sample_in;

    // divider setup values
    assign diff     = $signed({1'b0, hi_c}) - $signed({1'b0, lo_c});
    assign diff_mag = diff[GAIN_W] ? GAIN_W'(-diff) : diff[GAIN_W-1:0];

    // one restoring division step
    assign rem_sh   = {rem_reg, dq_reg[ACC_W-1]};
    assign ge       = rem_sh >= {1'b0, dvsr_reg};
    assign rem_step = ge ? DVSR_W'(rem_sh - {1'b0, dvsr_reg}) : rem_sh[DVSR_W-1:0];
    assign dq_step  = {dq_reg[ACC_W-2:0], ge};

    assign stat.div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    // signed step from the final quotient
    assign q_ext = $signed({1'b0, dq_step});
    always_comb
    begin
        if (empty_reg)
        begin
            inc_new = '0;
        end
        else if (neg_reg)
        begin
            inc_new = -q_ext;
        end
        else
        begin
            inc_new = q_ext;
        end
    end

    // accumulator advance, clamped to 0..2
    assign inc_src = cmd.finish ? inc_new : inc_reg;
    assign acc_sum = $signed({2'b00, acc_reg}) + $signed({inc_src[INC_W-1], inc_src});

    always_comb
    begin
        if (acc_sum < 0)
        begin
            acc_clamped = '0;
        end
        else if (acc_sum > $signed((INC_W+1)'(1) <<< (ACC_W - 1)))
        begin
            acc_clamped = ACC_W'(1) << (ACC_W - 1);
        end
        else
        begin
            acc_clamped = acc_sum[ACC_W-1:0];
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_gain_reg   <= '0;
            high_gain_reg  <= HIGH_GAIN_RST;
            fade_start_reg <= '0;
            fade_end_reg   <= '0;
            fade_out_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOW_GAIN:   low_gain_reg   <= cfg_wdata[GAIN_W-1:0];
                CFG_HIGH_GAIN:  high_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_FADE_START: fade_start_reg <= cfg_wdata[BOUND_W-1:0];
                CFG_FADE_END:   fade_end_reg   <= cfg_wdata[BOUND_W-1:0];
                CFG_FADE_OUT:   fade_out_reg   <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    // index, accumulator and step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            acc_reg  <= '0;
            inc_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            idx_reg <= (cur_idx == IW'(MAX_SAMPLES - 1)) ? '0 : cur_idx + IW'(1);
            if (cmd.first)
            begin
                acc_reg  <= start_acc;
                pend_reg <= in_win;
            end
            else if (in_win)
            begin
                acc_reg <= acc_clamped;
            end
        end
        else if (cmd.finish)
        begin
            inc_reg <= inc_new;
            if (pend_reg)
            begin
                acc_reg <= acc_clamped;
            end
        end
    end

    // gain step divider
    always_ff @(posedge clk)
    begin
        if (cmd.first)
        begin
            dq_reg    <= {diff_mag, {FRAC_EXTRA{1'b0}}};
            rem_reg   <= '0;
            dvsr_reg  <= DVSR_W'({1'b0, fade_end_reg} - {1'b0, fade_start_reg} + DVSR_W'(1));
            cnt_reg   <= '0;
            neg_reg   <= diff[GAIN_W] ^ fade_out_reg;
            empty_reg <= !win_ok;
        end
        else if (cmd.step)
        begin
            dq_reg  <= dq_step;
            rem_reg <= rem_step;
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_out_reg <= res;
            in_fade_reg    <= in_win;
        end
    end

    assign sample_out = sample_out_reg;
    assign in_fade    = in_fade_reg;

endmodule

// File: sv/linear_fade_gain_ramp_top.sv
// top level of the linear fade gain ramp
// a result is offered in the cycle after its item is accepted
// throughput: one item per cycle while no buffer opens and the output is not stalled
// an item that opens a buffer runs the gain step divider, so the next item is
// taken only once the division is done
// reset (rst_n low, asynchronous): gains 0 and unity, window 0..0, fade in,
// index, gain and step cleared, output empty
`timescale 1ns / 1ps

module linear_fade_gain_ramp_top import lfgr_pkg::*; #(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    lfgr_in_if.sink               in_ch,
    lfgr_out_if.source            out_ch
);

    lfgr_cmd_t  cmd;
    lfgr_stat_t stat;

    // control
    lfgr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_first  (in_ch.buffer_first),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // arithmetic
    lfgr_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .sample_in  (in_ch.sample_in),
        .cmd        (cmd),
        .stat       (stat),
        .sample_out (out_ch.sample_out),
        .in_fade    (out_ch.in_fade)
    );

endmodule

// File: sv/lfgr_chk.sv
// port level checks for the linear fade gain ramp, bound to the top level
`timescale 1ns / 1ps

module lfgr_chk import lfgr_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          buffer_first,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] sample_out,
    input logic                          in_fade
);

    // input only taken when the output slot is free or draining
    a_ready_slot: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!out_valid || out_ready))
        else $error("input ready while output slot blocked");

    // every accepted item shows a result next cycle
    a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted item without result");

    // a buffer start holds off the next item while the step is divided
    a_first_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && buffer_first) |=> !in_ready)
        else $error("input taken during step division");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sample_out) && $stable(in_fade)))
        else $error("stalled result changed");

endmodule

bind linear_fade_gain_ramp_top lfgr_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_lfgr_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .buffer_first (in_ch.buffer_first),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .sample_out   (out_ch.sample_out),
    .in_fade      (out_ch.in_fade)
);
